### hdl/lwpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwpg_pkg
// Shared constants, register indexes and structs of the load window
// performance-state governor.
// ----------------------------------------------------------------------------
package lwpg_pkg;

	// cpu population and derived widths
	localparam int NUM_CPUS = 64;
	localparam int DEPTH    = 64;
	localparam int MANAGED  = (NUM_CPUS < DEPTH) ? NUM_CPUS : DEPTH;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int HP_W     = $clog2(DEPTH + 1);
	localparam int TS_W     = 64;
	localparam int PS_W     = 3;
	localparam int LL_W     = 16;
	localparam int CNT8_W   = 8;
	localparam int NEED_W   = HP_W + CNT8_W + 1;
	localparam int CFG_A_W  = 3;

	localparam logic [PS_W-1:0] TOP_STATE = 3'd7;
	localparam logic [PS_W-1:0] LIMIT_RST = 3'd7;
	localparam logic [LL_W-1:0] LL_MAX    = 16'hFFFF;
	localparam logic [HP_W-1:0] HP_MAX    = HP_W'(MANAGED);
	localparam logic [IDX_W:0]  MANAGED_N = (IDX_W + 1)'(MANAGED);

	// configuration register indexes
	localparam logic [CFG_A_W-1:0] CFG_PS_CEILING     = 3'd0;
	localparam logic [CFG_A_W-1:0] CFG_WINDOW_TICKS   = 3'd1;
	localparam logic [CFG_A_W-1:0] CFG_STEPUP_TICKS   = 3'd2;
	localparam logic [CFG_A_W-1:0] CFG_STEPDOWN_TICKS = 3'd3;
	localparam logic [CFG_A_W-1:0] CFG_STEPDOWN_BASE  = 3'd4;
	localparam logic [CFG_A_W-1:0] CFG_STEPDOWN_GAIN  = 3'd5;

	typedef struct packed {
		logic [PS_W-1:0]   ps_ceiling;
		logic [TS_W-1:0]   window_ticks;
		logic [TS_W-1:0]   stepup_ticks;
		logic [TS_W-1:0]   stepdown_ticks;
		logic [CNT8_W-1:0] stepdown_base;
		logic [CNT8_W-1:0] stepdown_gain;
	} cfg_t;

	// one per-cpu memory word
	typedef struct packed {
		logic [TS_W-1:0] run_start;
		logic [TS_W-1:0] total_accum;
		logic [TS_W-1:0] idle_accum;
		logic [LL_W-1:0] low_load;
		logic [PS_W-1:0] pstate;
	} cpu_state_t;

	// memory write port
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		cpu_state_t       data;
	} state_wr_t;

	// item entering the decision stage
	typedef struct packed {
		logic             managed;
		logic             closed;
		logic             up;
		logic             down;
		logic [IDX_W-1:0] cpu;
		logic [PS_W-1:0]  cur_pstate;
		logic [LL_W-1:0]  ll;
		logic [LL_W-1:0]  ll_inc;
		logic [TS_W-1:0]  total;
		logic [TS_W-1:0]  idle;
		logic [TS_W-1:0]  wake;
		logic [TS_W-1:0]  idle_len;
	} dec_in_t;

	// result item
	typedef struct packed {
		logic [IDX_W-1:0] cpu_id;
		logic [PS_W-1:0]  new_pstate;
		logic             pstate_written;
		logic             window_closed;
		logic [TS_W-1:0]  window_total;
		logic [TS_W-1:0]  window_idle;
		logic [TS_W-1:0]  idle_length;
		logic [HP_W-1:0]  high_perf_count;
	} res_t;

endpackage

### hdl/lwpg_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwpg_in_if
// Idle episode channel: valid/ready with cpu and two timestamps.
// ----------------------------------------------------------------------------
interface lwpg_in_if;
	logic                        valid;
	logic                        ready;
	logic [lwpg_pkg::IDX_W-1:0]  cpu_index;
	logic [lwpg_pkg::TS_W-1:0]   idle_start_time;
	logic [lwpg_pkg::TS_W-1:0]   wake_time;

	modport source (output valid, cpu_index, idle_start_time, wake_time, input ready);
	modport sink   (input valid, cpu_index, idle_start_time, wake_time, output ready);
endinterface

### hdl/lwpg_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwpg_out_if
// Result channel: valid/ready with the governor decision of one episode.
// ----------------------------------------------------------------------------
interface lwpg_out_if;
	logic                        valid;
	logic                        ready;
	logic [lwpg_pkg::IDX_W-1:0]  cpu_id;
	logic [lwpg_pkg::PS_W-1:0]   new_pstate;
	logic                        pstate_written;
	logic                        window_closed;
	logic [lwpg_pkg::TS_W-1:0]   window_total;
	logic [lwpg_pkg::TS_W-1:0]   window_idle;
	logic [lwpg_pkg::TS_W-1:0]   idle_length;
	logic [lwpg_pkg::HP_W-1:0]   high_perf_count;

	modport source (output valid, cpu_id, new_pstate, pstate_written, window_closed,
		window_total, window_idle, idle_length, high_perf_count, input ready);
	modport sink   (input valid, cpu_id, new_pstate, pstate_written, window_closed,
		window_total, window_idle, idle_length, high_perf_count, output ready);
endinterface

### hdl/lwpg_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwpg_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lwpg_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [lwpg_pkg::CFG_A_W-1:0] addr;
	logic [lwpg_pkg::TS_W-1:0]    data;

	modport source (output valid, addr, data, input ready);
	modport sink   (input valid, addr, data, output ready);
endinterface

### hdl/load_window_pstate_governor_unit.sv
`timescale 1ns / 1ps
// An accepted item passes the stage registers s1, s2, s3 and s4, then the output register.
// Throughput: one item per cycle for distinct cpus while the output is not stalled;
// an item for a cpu still in flight waits until that cpu's write-back, so one cpu
// alone is limited by the read-modify-write loop through the state memory.
// Reset: all cpus at state zero with cleared accumulators (per-entry valid bits),
// high-performance count at the number of managed cpus, state ceiling 7.
// ----------------------------------------------------------------------------
// load_window_pstate_governor_unit
// Per-cpu load window governor: accumulates idle episodes in a per-cpu state
// memory and steps the performance state when a window closes.
// ----------------------------------------------------------------------------
module load_window_pstate_governor_unit (
	input  logic        clk,
	input  logic        arst_n,
	lwpg_in_if.sink     item_in,
	lwpg_out_if.source  result_out,
	lwpg_cfg_if.sink    cfg
);
	import lwpg_pkg::*;

	cfg_t             regs;
	cpu_state_t       rd_data;
	state_wr_t        wb;
	res_t             res;
	dec_in_t          d_s4;

	logic             ld1, ld2, ld3, ld4, ld_out;
	logic             hazard;
	logic             accept;
	logic             fire;

	logic             vld_s1, vld_s2, vld_s3, vld_s4;
	logic [IDX_W-1:0] cpu_s1, cpu_s2, cpu_s3;
	logic             managed_s1, managed_s2, managed_s3;
	logic [TS_W-1:0]  wake_s1, wake_s2, wake_s3;
	logic [TS_W-1:0]  idle_len_s1, idle_len_s2, idle_len_s3;
	logic [TS_W-1:0]  total_s2, total_s3;
	logic [TS_W-1:0]  idle_s2, idle_s3;
	logic [TS_W-1:0]  busy_s3;
	logic [LL_W-1:0]  ll_s2, ll_s3;
	logic [PS_W-1:0]  ps_s2, ps_s3;
	logic             closed_s3;

	res_t             out_q;
	logic             out_vld_q;

	lwpg_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	lwpg_state_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (item_in.cpu_index),
		.rd_data (rd_data),
		.wr      (wb)
	);

	lwpg_decide u_dec (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.d      (d_s4),
		.cfg    (regs),
		.wb     (wb),
		.res    (res)
	);

	// stage load enables, each stage moves when the next one frees
	assign ld_out = !out_vld_q || result_out.ready;
	assign ld4    = !vld_s4 || ld_out;
	assign ld3    = !vld_s3 || ld4;
	assign ld2    = !vld_s2 || ld3;
	assign ld1    = !vld_s1 || ld2;
	assign fire   = vld_s4 && ld_out;

	// same-cpu interlock until the earlier item is written back
	assign hazard = (vld_s1 && (cpu_s1 == item_in.cpu_index))
	             || (vld_s2 && (cpu_s2 == item_in.cpu_index))
	             || (vld_s3 && (cpu_s3 == item_in.cpu_index))
	             || (vld_s4 && (d_s4.cpu == item_in.cpu_index));

	assign item_in.ready = ld1 && !hazard;
	assign accept        = item_in.valid && item_in.ready;

	// stage valids and output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (ld1) vld_s1 <= accept;
			if (ld2) vld_s2 <= vld_s1;
			if (ld3) vld_s3 <= vld_s2;
			if (ld4) vld_s4 <= vld_s3;
			if (ld_out) out_vld_q <= vld_s4;
		end
	end

	// stage 1: episode length, memory read in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			cpu_s1      <= item_in.cpu_index;
			managed_s1  <= {1'b0, item_in.cpu_index} < MANAGED_N;
			wake_s1     <= item_in.wake_time;
			idle_len_s1 <= item_in.wake_time - item_in.idle_start_time;
		end
	end

	// stage 2: accumulate elapsed and idle time
	always_ff @(posedge clk) begin
		if (ld2) begin
			cpu_s2      <= cpu_s1;
			managed_s2  <= managed_s1;
			wake_s2     <= wake_s1;
			idle_len_s2 <= idle_len_s1;
			total_s2    <= rd_data.total_accum + wake_s1 - rd_data.run_start;
			idle_s2     <= rd_data.idle_accum + idle_len_s1;
			ll_s2       <= rd_data.low_load;
			ps_s2       <= rd_data.pstate;
		end
	end

	// stage 3: window close check and busy time
	always_ff @(posedge clk) begin
		if (ld3) begin
			cpu_s3      <= cpu_s2;
			managed_s3  <= managed_s2;
			wake_s3     <= wake_s2;
			idle_len_s3 <= idle_len_s2;
			total_s3    <= total_s2;
			idle_s3     <= idle_s2;
			ll_s3       <= ll_s2;
			ps_s3       <= ps_s2;
			closed_s3   <= total_s2 > regs.window_ticks;
			busy_s3     <= total_s2 - idle_s2;
		end
	end

	// stage 4: threshold compares and saturating counter increment
	always_ff @(posedge clk) begin
		if (ld4) begin
			d_s4.managed    <= managed_s3;
			d_s4.closed     <= closed_s3;
			d_s4.up         <= busy_s3 > regs.stepup_ticks;
			d_s4.down       <= busy_s3 < regs.stepdown_ticks;
			d_s4.cpu        <= cpu_s3;
			d_s4.cur_pstate <= ps_s3;
			d_s4.ll         <= ll_s3;
			d_s4.ll_inc     <= (ll_s3 == LL_MAX) ? ll_s3 : ll_s3 + LL_W'(1);
			d_s4.total      <= total_s3;
			d_s4.idle       <= idle_s3;
			d_s4.wake       <= wake_s3;
			d_s4.idle_len   <= idle_len_s3;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= res;
		end
	end

	assign result_out.valid           = out_vld_q;
	assign result_out.cpu_id          = out_q.cpu_id;
	assign result_out.new_pstate      = out_q.new_pstate;
	assign result_out.pstate_written  = out_q.pstate_written;
	assign result_out.window_closed   = out_q.window_closed;
	assign result_out.window_total    = out_q.window_total;
	assign result_out.window_idle     = out_q.window_idle;
	assign result_out.idle_length     = out_q.idle_length;
	assign result_out.high_perf_count = out_q.high_perf_count;

	// a new read never targets the entry written in the same cycle
	a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && wb.en) |-> (wb.addr != item_in.cpu_index))
		else $error("read and write-back of the same cpu entry overlap");

	// a state write only happens on a closed window
	a_write_needs_close: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.pstate_written) |-> out_q.window_closed)
		else $error("state write without a closed window");

	// high-performance count bounded by managed cpus
	a_hp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (out_q.high_perf_count <= HP_MAX))
		else $error("high-performance count out of range");

	// a stalled decision stage keeps its item
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && !ld_out) |=> (vld_s4 && $stable(d_s4.cpu)))
		else $error("decision stage lost a stalled item");

endmodule

### hdl/lwpg_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwpg_cfg_regs
// Configuration register file, written through the config channel.
// ----------------------------------------------------------------------------
module lwpg_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	lwpg_cfg_if.sink          cfg,
	output lwpg_pkg::cfg_t    regs
);
	import lwpg_pkg::*;

	cfg_t regs_q;

	// writes always taken
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// register writes by index, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.ps_ceiling     <= LIMIT_RST;
			regs_q.window_ticks   <= '0;
			regs_q.stepup_ticks   <= '0;
			regs_q.stepdown_ticks <= '0;
			regs_q.stepdown_base  <= '0;
			regs_q.stepdown_gain  <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				CFG_PS_CEILING:     regs_q.ps_ceiling     <= cfg.data[PS_W-1:0];
				CFG_WINDOW_TICKS:   regs_q.window_ticks   <= cfg.data;
				CFG_STEPUP_TICKS:   regs_q.stepup_ticks   <= cfg.data;
				CFG_STEPDOWN_TICKS: regs_q.stepdown_ticks <= cfg.data;
				CFG_STEPDOWN_BASE:  regs_q.stepdown_base  <= cfg.data[CNT8_W-1:0];
				CFG_STEPDOWN_GAIN:  regs_q.stepdown_gain  <= cfg.data[CNT8_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

### hdl/lwpg_state_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwpg_state_mem
// Per-cpu state memory, one read and one write port, registered read.
// Entries never written read as zero through a valid bit per entry.
// ----------------------------------------------------------------------------
module lwpg_state_mem (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [lwpg_pkg::IDX_W-1:0]  rd_addr,
	output lwpg_pkg::cpu_state_t        rd_data,
	input  lwpg_pkg::state_wr_t         wr
);
	import lwpg_pkg::*;

	cpu_state_t       mem_q [DEPTH];
	cpu_state_t       rd_raw_q;
	logic [DEPTH-1:0] ent_vld_q;
	logic             rd_vld_q;

	// storage array and read data
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_raw_q <= mem_q[rd_addr];
		end
	end

	// written-entry flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (wr.en) begin
				ent_vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= ent_vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_raw_q : '0;

endmodule

### hdl/lwpg_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwpg_decide
// Final stage: low-load counting, state request with clamping, the global
// count of cpus at state zero, write-back word and result item.
// ----------------------------------------------------------------------------
module lwpg_decide (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  lwpg_pkg::dec_in_t    d,
	input  lwpg_pkg::cfg_t       cfg,
	output lwpg_pkg::state_wr_t  wb,
	output lwpg_pkg::res_t       res
);
	import lwpg_pkg::*;

	logic [HP_W-1:0]        hp_q;
	logic [HP_W-1:0]        hp_d;
	logic [HP_W+CNT8_W-1:0] prod;
	logic [NEED_W-1:0]      need;
	logic                   req;
	logic [PS_W:0]          target_w;
	logic [PS_W-1:0]        tgt;
	logic [PS_W-1:0]        cur_new;
	logic [LL_W-1:0]        ll_new;
	logic                   written;
	logic                   do_close;

	// step-down threshold from current high-performance count
	assign prod     = hp_q * cfg.stepdown_gain;
	assign need     = {1'b0, prod} + NEED_W'(cfg.stepdown_base);
	assign do_close = d.managed && d.closed;

	// move selection and clamped request
	always_comb begin
		req      = 1'b0;
		target_w = '0;
		ll_new   = d.ll;
		tgt      = '0;
		cur_new  = d.cur_pstate;
		written  = 1'b0;
		hp_d     = hp_q;
		if (do_close) begin
			if (d.up) begin
				ll_new = '0;
				req    = 1'b1;
			end else if (d.down) begin
				if (d.ll_inc > need) begin
					ll_new   = '0;
					req      = 1'b1;
					target_w = {1'b0, d.cur_pstate} + (PS_W + 1)'(1);
				end else begin
					ll_new = d.ll_inc;
				end
			end
		end
		tgt = (target_w > {1'b0, TOP_STATE}) ? TOP_STATE : target_w[PS_W-1:0];
		if (tgt > cfg.ps_ceiling) begin
			tgt = cfg.ps_ceiling;
		end
		if (req && (cfg.ps_ceiling != '0) && (tgt != d.cur_pstate)) begin
			written = 1'b1;
			cur_new = tgt;
			if (tgt == '0) begin
				if (hp_q < HP_MAX) begin
					hp_d = hp_q + HP_W'(1);
				end
			end else if (d.cur_pstate == '0) begin
				if (hp_q != '0) begin
					hp_d = hp_q - HP_W'(1);
				end
			end
		end
	end

	// global count of cpus at state zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q <= HP_MAX;
		end else if (fire) begin
			hp_q <= hp_d;
		end
	end

	// write-back word
	always_comb begin
		wb.en                  = fire && d.managed;
		wb.addr                = d.cpu;
		wb.data.run_start      = d.wake;
		wb.data.total_accum    = do_close ? '0 : d.total;
		wb.data.idle_accum     = do_close ? '0 : d.idle;
		wb.data.low_load       = ll_new;
		wb.data.pstate         = cur_new;
	end

	// result item
	always_comb begin
		res.cpu_id          = d.cpu;
		res.new_pstate      = d.managed ? cur_new : '0;
		res.pstate_written  = written;
		res.window_closed   = do_close;
		res.window_total    = do_close ? d.total : '0;
		res.window_idle     = do_close ? d.idle : '0;
		res.idle_length     = d.idle_len;
		res.high_perf_count = hp_d;
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the load window performance-state governor. A short
// directed table covers the reset settings, timestamp extremes, wrap-around,
// limit clamps, frozen states and step up/down. Random phases with fresh
// register settings follow. Each result item is compared field by field with
// its table value or the in-bench model; both channels get random stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import lwpg_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYC  = 8;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 100;
	localparam int HOLD_CYC    = 400;

	typedef enum logic [0:0] {ROW_EPISODE, ROW_SETTINGS} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic [IDX_W-1:0] cpu;
		logic [TS_W-1:0]  t_idle;
		logic [TS_W-1:0]  t_wake;
		bit               known;
		res_t             want;
		cfg_t             regs;
	} row_t;

	logic clk;
	logic arst_n;

	lwpg_in_if  item_if ();
	lwpg_out_if res_if ();
	lwpg_cfg_if cfg_if ();

	load_window_pstate_governor_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_if),
		.result_out (res_if),
		.cfg        (cfg_if)
	);

	// governor model state
	cfg_t            gv_cfg;
	logic [TS_W-1:0] gv_run_start [DEPTH];
	logic [TS_W-1:0] gv_total     [DEPTH];
	logic [TS_W-1:0] gv_idle      [DEPTH];
	logic [LL_W-1:0] gv_low_load  [DEPTH];
	logic [PS_W-1:0] gv_pstate    [DEPTH];
	int unsigned     gv_hp;

	res_t pending_decisions [$];
	row_t directed_rows [$];
	int   mismatch_count = 0;
	bit   tx_gaps = 1'b1;
	bit   rx_gaps = 1'b1;
	bit   hold_req = 1'b0;

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// idle length: mostly none, sometimes short, rarely long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic res_t mk_res(input logic [IDX_W-1:0] c, input logic [PS_W-1:0] ps,
		input logic wr, input logic cl, input logic [TS_W-1:0] tot, input logic [TS_W-1:0] idl,
		input logic [TS_W-1:0] len, input logic [HP_W-1:0] hp);
		res_t r;
		r.cpu_id          = c;
		r.new_pstate      = ps;
		r.pstate_written  = wr;
		r.window_closed   = cl;
		r.window_total    = tot;
		r.window_idle     = idl;
		r.idle_length     = len;
		r.high_perf_count = hp;
		return r;
	endfunction

	function automatic cfg_t make_settings(input logic [PS_W-1:0] lim,
		input logic [TS_W-1:0] win, input logic [TS_W-1:0] up, input logic [TS_W-1:0] down,
		input logic [CNT8_W-1:0] base, input logic [CNT8_W-1:0] gain);
		cfg_t s;
		s.ps_ceiling     = lim;
		s.window_ticks   = win;
		s.stepup_ticks   = up;
		s.stepdown_ticks = down;
		s.stepdown_base  = base;
		s.stepdown_gain  = gain;
		return s;
	endfunction

	// table rows
	function automatic void ep(input logic [IDX_W-1:0] c, input logic [TS_W-1:0] ti,
		input logic [TS_W-1:0] tw);
		row_t r;
		r = '{kind: ROW_EPISODE, cpu: c, t_idle: ti, t_wake: tw, known: 1'b0,
			want: '0, regs: '0};
		directed_rows.push_back(r);
	endfunction

	function automatic void ep_known(input logic [IDX_W-1:0] c, input logic [TS_W-1:0] ti,
		input logic [TS_W-1:0] tw, input res_t want);
		row_t r;
		r = '{kind: ROW_EPISODE, cpu: c, t_idle: ti, t_wake: tw, known: 1'b1,
			want: want, regs: '0};
		directed_rows.push_back(r);
	endfunction

	function automatic void reg_row(input cfg_t s);
		row_t r;
		r = '{kind: ROW_SETTINGS, cpu: '0, t_idle: '0, t_wake: '0, known: 1'b0,
			want: '0, regs: s};
		directed_rows.push_back(r);
	endfunction

	// state move request with clamps; 1 when a write is issued
	function automatic bit request_move(input int unsigned c, input int unsigned target);
		int unsigned lim;
		int unsigned prev;
		int unsigned t;
		lim = gv_cfg.ps_ceiling;
		t = target;
		if (lim == 0)
			return 1'b0;
		if (t > TOP_STATE)
			t = TOP_STATE;
		if (t > lim)
			t = lim;
		prev = gv_pstate[c];
		if (prev == t)
			return 1'b0;
		gv_pstate[c] = PS_W'(t);
		if (t == 0) begin
			if (gv_hp < MANAGED)
				gv_hp++;
		end else if (prev == 0) begin
			if (gv_hp > 0)
				gv_hp--;
		end
		return 1'b1;
	endfunction

	// decision for one idle episode, updates the model state
	function automatic res_t govern_episode(input logic [IDX_W-1:0] c,
		input logic [TS_W-1:0] t_idle, input logic [TS_W-1:0] t_wake);
		res_t            r;
		logic [TS_W-1:0] busy;
		int unsigned     need;
		r = '0;
		r.cpu_id = c;
		r.idle_length = t_wake - t_idle;
		if (int'(c) < MANAGED) begin
			gv_total[c] = gv_total[c] + (t_wake - gv_run_start[c]);
			gv_idle[c]  = gv_idle[c] + r.idle_length;
			if (gv_total[c] > gv_cfg.window_ticks) begin
				busy = gv_total[c] - gv_idle[c];
				r.window_closed = 1'b1;
				r.window_total  = gv_total[c];
				r.window_idle   = gv_idle[c];
				if (busy > gv_cfg.stepup_ticks) begin
					r.pstate_written = request_move(c, 0);
					gv_low_load[c] = '0;
				end else if (busy < gv_cfg.stepdown_ticks) begin
					need = int'(gv_cfg.stepdown_base) + gv_hp * int'(gv_cfg.stepdown_gain);
					if (gv_low_load[c] < LL_MAX)
						gv_low_load[c]++;
					if (int'(gv_low_load[c]) > need) begin
						gv_low_load[c] = '0;
						r.pstate_written = request_move(c, int'(gv_pstate[c]) + 1);
					end
				end
				gv_total[c] = '0;
				gv_idle[c]  = '0;
			end
			gv_run_start[c] = t_wake;
			r.new_pstate = gv_pstate[c];
		end
		r.high_perf_count = HP_W'(gv_hp);
		return r;
	endfunction

	// offer one episode, wait for it to be taken, record its decision
	task automatic send_episode(input logic [IDX_W-1:0] c, input logic [TS_W-1:0] ti,
		input logic [TS_W-1:0] tw, input bit known, input res_t want);
		int   g;
		res_t guess;
		g = tx_gaps ? gap_len() : 0;
		if (g > 0) begin
			item_if.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		item_if.valid           <= 1'b1;
		item_if.cpu_index       <= c;
		item_if.idle_start_time <= ti;
		item_if.wake_time       <= tw;
		@(posedge clk);
		while (item_if.ready !== 1'b1) @(posedge clk);
		guess = govern_episode(c, ti, tw);
		pending_decisions.push_back(known ? want : guess);
	endtask

	// stop offering and wait until the pipeline is empty
	task automatic settle();
		item_if.valid <= 1'b0;
		while (pending_decisions.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// write all six registers back to back
	task automatic program_regs(input cfg_t s);
		logic [CFG_A_W-1:0] idx [6];
		logic [TS_W-1:0]    val [6];
		idx = '{CFG_PS_CEILING, CFG_WINDOW_TICKS, CFG_STEPUP_TICKS,
			CFG_STEPDOWN_TICKS, CFG_STEPDOWN_BASE, CFG_STEPDOWN_GAIN};
		val = '{TS_W'(s.ps_ceiling), s.window_ticks, s.stepup_ticks,
			s.stepdown_ticks, TS_W'(s.stepdown_base), TS_W'(s.stepdown_gain)};
		for (int i = 0; i < 6; i++) begin
			cfg_if.valid <= 1'b1;
			cfg_if.addr  <= idx[i];
			cfg_if.data  <= val[i];
			@(posedge clk);
			while (cfg_if.ready !== 1'b1) @(posedge clk);
		end
		cfg_if.valid <= 1'b0;
		gv_cfg = s;
	endtask

	task automatic check_field(input string name, input logic [TS_W-1:0] want,
		input logic [TS_W-1:0] got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// result side: check accepted items, drive ready with gaps and one long hold
	initial begin : result_sink
		res_t got;
		res_t want;
		int   low_left;
		bit   held;
		low_left = 0;
		held = 1'b0;
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
				got.cpu_id          = res_if.cpu_id;
				got.new_pstate      = res_if.new_pstate;
				got.pstate_written  = res_if.pstate_written;
				got.window_closed   = res_if.window_closed;
				got.window_total    = res_if.window_total;
				got.window_idle     = res_if.window_idle;
				got.idle_length     = res_if.idle_length;
				got.high_perf_count = res_if.high_perf_count;
				if (pending_decisions.size() == 0) begin
					$display("%0t unexpected result item: expected none actual cpu %0d",
						$time, got.cpu_id);
					mismatch_count++;
				end else begin
					want = pending_decisions.pop_front();
					check_field("cpu_id", TS_W'(want.cpu_id), TS_W'(got.cpu_id));
					check_field("new_pstate", TS_W'(want.new_pstate), TS_W'(got.new_pstate));
					check_field("pstate_written", TS_W'(want.pstate_written),
						TS_W'(got.pstate_written));
					check_field("window_closed", TS_W'(want.window_closed),
						TS_W'(got.window_closed));
					check_field("window_total", want.window_total, got.window_total);
					check_field("window_idle", want.window_idle, got.window_idle);
					check_field("idle_length", want.idle_length, got.idle_length);
					check_field("high_perf_count", TS_W'(want.high_perf_count),
						TS_W'(got.high_perf_count));
				end
			end
			if (low_left > 0) begin
				low_left--;
				res_if.ready <= 1'b0;
			end else if (hold_req && !held) begin
				held = 1'b1;
				low_left = HOLD_CYC - 1;
				res_if.ready <= 1'b0;
			end else begin
				low_left = rx_gaps ? gap_len() : 0;
				if (low_left > 0) begin
					low_left--;
					res_if.ready <= 1'b0;
				end else begin
					res_if.ready <= 1'b1;
				end
			end
		end
	end

	// watchdog on cycles with no handshake anywhere
	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((item_if.valid === 1'b1 && item_if.ready === 1'b1) ||
				(res_if.valid === 1'b1 && res_if.ready === 1'b1) ||
				(cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t watchdog: no handshake for %0d cycles", $time, quiet);
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	// stimulus
	initial begin : stimulus
		cfg_t             s;
		row_t             row;
		logic [IDX_W-1:0] c;
		logic [TS_W-1:0]  ti;
		logic [TS_W-1:0]  tw;
		int unsigned      w;

		arst_n                  <= 1'b0;
		item_if.valid           <= 1'b0;
		item_if.cpu_index       <= '0;
		item_if.idle_start_time <= '0;
		item_if.wake_time       <= '0;
		cfg_if.valid            <= 1'b0;
		cfg_if.addr             <= '0;
		cfg_if.data             <= '0;

		// model reset
		gv_cfg = make_settings(LIMIT_RST, '0, '0, '0, '0, '0);
		for (int i = 0; i < DEPTH; i++) begin
			gv_run_start[i] = '0;
			gv_total[i]     = '0;
			gv_idle[i]      = '0;
			gv_low_load[i]  = '0;
			gv_pstate[i]    = '0;
		end
		gv_hp = MANAGED;

		// reset settings, timestamp extremes and wrap of the idle length
		ep_known(6'd0, 64'd100, 64'd150, mk_res(6'd0, 3'd0, 1'b0, 1'b1, 64'd150, 64'd50,
			64'd50, 7'd64));
		ep_known(6'd63, '0, '1, mk_res(6'd63, 3'd0, 1'b0, 1'b1, '1, '1, '1, 7'd64));
		ep_known(6'd1, '1, '0, mk_res(6'd1, 3'd0, 1'b0, 1'b0, '0, '0, 64'd1, 7'd64));
		ep(6'd1, 64'd10, 64'd20);
		// every window counts as low load: step down until the top state
		reg_row(make_settings(3'd7, '0, '1, '1, 8'd0, 8'd0));
		ep_known(6'd2, 64'd10, 64'd20, mk_res(6'd2, 3'd1, 1'b1, 1'b1, 64'd20, 64'd10,
			64'd10, 7'd63));
		for (int k = 1; k <= 7; k++)
			ep(6'd2, 64'(20 * k + 10), 64'(20 * k + 20));
		// lowered limit pulls the cpu down to the limit
		reg_row(make_settings(3'd3, '0, '1, '1, 8'd0, 8'd0));
		ep(6'd2, 64'd170, 64'd180);
		// frozen states
		reg_row(make_settings(3'd0, '0, '1, '1, 8'd0, 8'd0));
		ep(6'd3, 64'd5, 64'd9);
		// busy window jumps to state zero
		reg_row(make_settings(3'd7, '0, '0, '0, 8'd0, 8'd0));
		ep(6'd2, 64'd200, 64'd210);
		// widest window never closes
		reg_row(make_settings(3'd5, '1, '0, '1, 8'hFF, 8'hFF));
		ep(6'd4, 64'd7, '1);
		// window equal to its length stays open, one tick more closes it
		reg_row(make_settings(3'd7, 64'd100, '1, '1, 8'd1, 8'd0));
		ep(6'd6, 64'd50, 64'd100);
		ep(6'd6, 64'd101, 64'd101);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_SETTINGS) begin
				settle();
				program_regs(row.regs);
			end else begin
				send_episode(row.cpu, row.t_idle, row.t_wake, row.known, row.want);
			end
		end

		// random phases, each under fresh settings
		for (int p = 0; p < PHASES; p++) begin
			settle();
			w = $urandom_range(200, 3000);
			s.ps_ceiling     = PS_W'($urandom_range(1, 7));
			s.window_ticks   = TS_W'(w);
			s.stepup_ticks   = TS_W'($urandom_range(w / 4, w));
			s.stepdown_ticks = TS_W'($urandom_range(0, int'(s.stepup_ticks)));
			s.stepdown_base  = CNT8_W'($urandom_range(0, 3));
			s.stepdown_gain  = ($urandom_range(0, 3) == 0) ? 8'd1 : 8'd0;
			case (p)
				1: s.ps_ceiling = 3'd0;
				2: begin
					s.stepdown_base = 8'hFF;
					s.stepdown_gain = 8'hFF;
				end
				3: s.window_ticks = '0;
				5: s.ps_ceiling = 3'd1;
				6: s.stepup_ticks = '1;
				8: s.window_ticks = '1;
				default: ;
			endcase
			program_regs(s);
			// some phases run with no idling on either side
			tx_gaps = (p % 4 != 1) && (p != 4);
			rx_gaps = (p % 4 != 1);
			if (p == 0)
				send_episode(6'd5, '1 - 64'd300, '1 - 64'd200, 1'b0, '0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 4 && n == 30)
					hold_req = 1'b1;
				if ($urandom_range(0, 99) < 85) begin
					// well-formed episode continuing this cpu's timeline
					c = ($urandom_range(0, 3) != 0) ? IDX_W'($urandom_range(0, 3))
						: IDX_W'($urandom_range(0, 63));
					ti = gv_run_start[c] + TS_W'($urandom_range(0, 1) ?
						$urandom_range(0, 20) : $urandom_range(0, 400));
					tw = ti + TS_W'($urandom_range(0, 300));
				end else begin
					c  = IDX_W'($urandom);
					ti = {$urandom, $urandom};
					tw = $urandom_range(0, 1) ? {$urandom, $urandom}
						: ti + TS_W'($urandom_range(0, 1000));
				end
				send_episode(c, ti, tw, 1'b0, '0);
			end
		end

		settle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

### files.f
hdl/lwpg_pkg.sv
hdl/lwpg_in_if.sv
hdl/lwpg_out_if.sv
hdl/lwpg_cfg_if.sv
hdl/lwpg_cfg_regs.sv
hdl/lwpg_state_mem.sv
hdl/lwpg_decide.sv
hdl/load_window_pstate_governor_unit.sv
tb/tb_top.sv
